>>> rtl/core/rmq_pkg.sv
// Shared types, widths and constants for the rotation matrix to quaternion block.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 30;
    localparam int DW = 32;
    localparam int VW = 64;   // branch vector component, exact signed for FRAC_BITS up to 60
    localparam int MW = 30;   // scaled magnitude, below 2^30
    localparam int SW = 62;   // sum of four squares, below 2^62
    localparam int NW = 31;   // integer square root
    localparam int QW = 64;   // quotient register width
    localparam int CSTAGES = 31;  // root iterations, one result bit each

    // Branch vector: magnitudes plus signs, with the zero flag
    typedef struct packed {
        logic [3:0]          neg;
        logic [3:0][MW-1:0]  mag;
        logic                zero;
    } vec_t;

    // Per-component divide state
    typedef struct packed {
        logic [MW+1:0] rem;
        logic [QW-1:0] quo;
    } div_t;

endpackage

>>> rtl/core/rmq_sqrt_cell.sv
// One step of the restoring integer square root; holds a vector beside it.
module rmq_sqrt_cell import rmq_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            vld_in,
    input  logic [SW-1:0]   rad_in,
    input  logic [SW-1:0]   res_in,
    input  vec_t            vec_in,
    output logic            vld_out,
    output logic [SW-1:0]   rad_out,
    output logic [SW-1:0]   res_out,
    output vec_t            vec_out
);
    localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * STEP);

    logic [SW-1:0] rad_next;
    logic [SW-1:0] res_next;
    logic          vld_reg;
    logic [SW-1:0] rad_reg;
    logic [SW-1:0] res_reg;
    vec_t          vec_reg;

    // compare-subtract step
    always_comb begin
        if (rad_in >= res_in + BIT) begin
            rad_next = rad_in - (res_in + BIT);
            res_next = (res_in >> 1) + BIT;
        end else begin
            rad_next = rad_in;
            res_next = res_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            rad_reg <= rad_next;
            res_reg <= res_next;
            vec_reg <= vec_in;
        end
    end

    assign vld_out = vld_reg;
    assign rad_out = rad_reg;
    assign res_out = res_reg;
    assign vec_out = vec_reg;
endmodule

>>> rtl/core/rmq_div_cell.sv
// One restoring division step for all four components at once.
module rmq_div_cell import rmq_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              vld_in,
    input  logic [NW-1:0]     n_in,
    input  logic [3:0]        neg_in,
    input  logic              zero_in,
    input  div_t [3:0]        st_in,
    output logic              vld_out,
    output logic [NW-1:0]     n_out,
    output logic [3:0]        neg_out,
    output logic              zero_out,
    output div_t [3:0]        st_out
);
    div_t [3:0]     st_next;
    logic           vld_reg;
    logic [NW-1:0]  n_reg;
    logic [3:0]     neg_reg;
    logic           zero_reg;
    div_t [3:0]     st_reg;

    // shift remainder, subtract divisor when it fits
    always_comb begin
        logic [MW+1:0] r;
        for (int i = 0; i < 4; i++) begin
            r = {st_in[i].rem[MW:0], 1'b0};
            st_next[i].quo = {st_in[i].quo[QW-2:0], 1'b0};
            if (r >= (MW+2)'(n_in)) begin
                r = r - (MW+2)'(n_in);
                st_next[i].quo[0] = 1'b1;
            end
            st_next[i].rem = r;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            n_reg    <= n_in;
            neg_reg  <= neg_in;
            zero_reg <= zero_in;
            st_reg   <= st_next;
        end
    end

    assign vld_out  = vld_reg;
    assign n_out    = n_reg;
    assign neg_out  = neg_reg;
    assign zero_out = zero_reg;
    assign st_out   = st_reg;
endmodule

>>> rtl/core/rotation_matrix_to_quaternion.sv
// Top level: branch select, scaling, square-root and divide cell chains, output skid.
// Throughput: one matrix per cycle while the chain is not stalled; each root or divide cell takes one bit per cycle
// and hands its item down the chain every cycle that the chain is enabled.
// Stall: the whole chain holds while the skid register holds a result.
// Reset: aresetn synchronous active low clears all valid bits; no clearing pass.
module rotation_matrix_to_quaternion import rmq_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [287:0]  s_tdata,   // m11, m12, m13, m21, m22, m23, m31, m32, m33
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata    // quat_w, quat_x, quat_y, quat_z
);
    localparam int DSTEPS = FRAC_BITS + 1;
    localparam logic signed [VW-1:0] ONE = VW'(64'sd1 <<< FRAC_BITS);

    logic en;

    // output register with skid: chain advances while the skid register is empty
    logic         out_vld_reg;
    logic         skid_vld_reg;
    logic [127:0] out_dat_reg;
    logic [127:0] skid_dat_reg;
    logic         tail_vld;
    logic [127:0] tail_dat;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    // ---- stage 1: register the matrix
    logic               v1_reg;
    logic signed [DW-1:0] m_reg [9];
    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_tvalid;
        if (en) begin
            for (int i = 0; i < 9; i++) m_reg[i] <= s_tdata[i*DW +: DW];
        end
    end

    // ---- stage 2: sums, trace and diagonal compares
    logic signed [VW-1:0] tr_c;
    logic signed [VW-1:0] d11, d22, d33, a32, a13, a21, p12, p13, p23;
    logic                 sel_tr, sel_11, sel_22;
    always_comb begin
        tr_c = VW'(m_reg[0]) + VW'(m_reg[4]) + VW'(m_reg[8]);
        d11  = ONE + VW'(m_reg[0]) - VW'(m_reg[4]) - VW'(m_reg[8]);
        d22  = ONE + VW'(m_reg[4]) - VW'(m_reg[0]) - VW'(m_reg[8]);
        d33  = ONE + VW'(m_reg[8]) - VW'(m_reg[0]) - VW'(m_reg[4]);
        a32  = VW'(m_reg[7]) - VW'(m_reg[5]);
        a13  = VW'(m_reg[2]) - VW'(m_reg[6]);
        a21  = VW'(m_reg[3]) - VW'(m_reg[1]);
        p12  = VW'(m_reg[1]) + VW'(m_reg[3]);
        p13  = VW'(m_reg[2]) + VW'(m_reg[6]);
        p23  = VW'(m_reg[5]) + VW'(m_reg[7]);
        sel_tr = tr_c > 0;
        sel_11 = (m_reg[0] > m_reg[4]) && (m_reg[0] > m_reg[8]);
        sel_22 = m_reg[4] > m_reg[8];
    end

    logic                 v2_reg;
    logic signed [VW-1:0] vv_reg [4];
    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en) v2_reg <= v1_reg;
        if (en) begin
            if (sel_tr) begin
                vv_reg[0] <= ONE + tr_c; vv_reg[1] <= a32;
                vv_reg[2] <= a13;        vv_reg[3] <= a21;
            end else if (sel_11) begin
                vv_reg[0] <= a32; vv_reg[1] <= d11[VW-1] ? '0 : d11;
                vv_reg[2] <= p12; vv_reg[3] <= p13;
            end else if (sel_22) begin
                vv_reg[0] <= a13; vv_reg[1] <= p12;
                vv_reg[2] <= d22[VW-1] ? '0 : d22; vv_reg[3] <= p23;
            end else begin
                vv_reg[0] <= a21; vv_reg[1] <= p13;
                vv_reg[2] <= p23; vv_reg[3] <= d33[VW-1] ? '0 : d33;
            end
        end
    end

    // ---- stage 3: magnitudes, signs, leading-one position of the maximum
    logic [VW-1:0] mg [4];
    logic [VW-1:0] orall;
    logic [5:0]    lead;
    always_comb begin
        orall = '0;
        for (int i = 0; i < 4; i++) begin
            mg[i] = vv_reg[i][VW-1] ? VW'(-vv_reg[i]) : VW'(vv_reg[i]);
            orall = orall | mg[i];
        end
        lead = '0;
        for (int b = 0; b < VW; b++) if (orall[b]) lead = 6'(b);
    end

    logic          v3_reg;
    logic [VW-1:0] mg_reg [4];
    logic [3:0]    ng_reg;
    logic [5:0]    ld_reg;
    logic          z3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en) v3_reg <= v2_reg;
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                mg_reg[i] <= mg[i];
                ng_reg[i] <= vv_reg[i][VW-1];
            end
            ld_reg <= lead;
            z3_reg <= orall == '0;
        end
    end

    // ---- stage 4: common shift to put the maximum's leading one at bit 29
    vec_t vs_c;
    always_comb begin
        vs_c.neg  = ng_reg;
        vs_c.zero = z3_reg;
        for (int i = 0; i < 4; i++) begin
            if (ld_reg >= 6'(MW - 1))
                vs_c.mag[i] = MW'(mg_reg[i] >> (ld_reg - 6'(MW - 1)));
            else
                vs_c.mag[i] = MW'(mg_reg[i] << (6'(MW - 1) - ld_reg));
        end
    end

    logic  v4_reg;
    vec_t  vs_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
        if (en) vs_reg <= vs_c;
    end

    // ---- stage 5: squares, one 30x30 product per component
    logic           v5_reg;
    logic [SW-3:0]  sq_reg [4];
    vec_t           vq_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
        if (en) begin
            for (int i = 0; i < 4; i++)
                sq_reg[i] <= (SW-2)'(vs_reg.mag[i]) * (SW-2)'(vs_reg.mag[i]);
            vq_reg <= vs_reg;
        end
    end

    // ---- stage 6: sum of squares
    logic          v6_reg;
    logic [SW-1:0] ss_reg;
    vec_t          vr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v6_reg <= 1'b0;
        else if (en) v6_reg <= v5_reg;
        if (en) begin
            ss_reg <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]) + SW'(sq_reg[3]);
            vr_reg <= vq_reg;
        end
    end

    // ---- square-root cell chain
    logic          sv  [CSTAGES+1];
    logic [SW-1:0] srad [CSTAGES+1];
    logic [SW-1:0] sres [CSTAGES+1];
    vec_t          svec [CSTAGES+1];
    assign sv[0]   = v6_reg;
    assign srad[0] = ss_reg;
    assign sres[0] = '0;
    assign svec[0] = vr_reg;

    for (genvar g = 0; g < CSTAGES; g++) begin : g_sqrt
        rmq_sqrt_cell #(.STEP(g)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(sv[g]), .rad_in(srad[g]), .res_in(sres[g]), .vec_in(svec[g]),
            .vld_out(sv[g+1]), .rad_out(srad[g+1]), .res_out(sres[g+1]),
            .vec_out(svec[g+1])
        );
    end

    // ---- divide cell chain: mag <= n, so the integer quotient part is 0 or 1
    logic           dv   [DSTEPS+1];
    logic [NW-1:0]  dn   [DSTEPS+1];
    logic [3:0]     dneg [DSTEPS+1];
    logic           dz   [DSTEPS+1];
    div_t [3:0]     dst  [DSTEPS+1];
    logic [NW-1:0]  n0;
    assign n0      = NW'(sres[CSTAGES]);
    assign dv[0]   = sv[CSTAGES];
    assign dn[0]   = n0;
    assign dneg[0] = svec[CSTAGES].neg;
    assign dz[0]   = svec[CSTAGES].zero;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if ((NW'(svec[CSTAGES].mag[i]) >= n0) && (n0 != '0)) begin
                dst[0][i].quo = QW'(1);
                dst[0][i].rem = (MW+2)'(NW'(svec[CSTAGES].mag[i]) - n0);
            end else begin
                dst[0][i].quo = '0;
                dst[0][i].rem = (MW+2)'(svec[CSTAGES].mag[i]);
            end
        end
    end

    for (genvar g = 0; g < DSTEPS; g++) begin : g_div
        rmq_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .vld_in(dv[g]), .n_in(dn[g]), .neg_in(dneg[g]), .zero_in(dz[g]),
            .st_in(dst[g]),
            .vld_out(dv[g+1]), .n_out(dn[g+1]), .neg_out(dneg[g+1]),
            .zero_out(dz[g+1]), .st_out(dst[g+1])
        );
    end

    // ---- round, saturate, apply sign
    always_comb begin
        logic [QW-1:0] q;
        tail_vld = dv[DSTEPS];
        for (int i = 0; i < 4; i++) begin
            q = (dst[DSTEPS][i].quo + QW'(1)) >> 1;
            if (dz[DSTEPS]) begin
                tail_dat[i*DW +: DW] = '0;
            end else if (dneg[DSTEPS][i]) begin
                if (q > QW'(64'h8000_0000)) q = QW'(64'h8000_0000);
                tail_dat[i*DW +: DW] = DW'(QW'(0) - q);
            end else begin
                if (q > QW'(64'h7FFF_FFFF)) q = QW'(64'h7FFF_FFFF);
                tail_dat[i*DW +: DW] = DW'(q);
            end
        end
    end

    // ---- output register and skid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (!out_vld_reg || m_tready) begin
                if (skid_vld_reg) begin
                    out_vld_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end else begin
                    out_vld_reg <= tail_vld;
                end
            end else if (tail_vld && en) begin
                skid_vld_reg <= 1'b1;
            end
        end
        if (!out_vld_reg || m_tready) begin
            out_dat_reg <= skid_vld_reg ? skid_dat_reg : tail_dat;
        end else if (tail_vld && en) begin
            skid_dat_reg <= tail_dat;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg;

`ifndef SYNTHESIS
    // skid holds data only while the output register is also full
    a_skid_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg) else $error("skid valid without output valid");

    // a stalled result is never lost from the output register
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // the chain is frozen while the skid is occupied
    a_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> !s_tready) else $error("ready while skid full");
`endif
endmodule

>>> sim/rotation_matrix_to_quaternion_tb.sv
// Testbench for the rotation matrix to quaternion block: random-gap stream driver, checker.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
    import rmq_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int WATCHDOG = 20000;
    localparam logic signed [31:0] ONE_Q = 32'sh4000_0000;
    localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MAXN = 32'sh8000_0000;

    typedef logic [287:0] matrix_t;
    typedef logic [127:0] quat_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    matrix_t s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    quat_t m_tdata;

    matrix_t pending_mats[$];
    quat_t quat_expected[$];
    int err_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit hold_req = 1'b0;
    bit drain_req = 1'b0;
    bit stim_done = 1'b0;

    rotation_matrix_to_quaternion u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // Integer square root, floor
    function automatic logic [63:0] isqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Predicted unit quaternion for one matrix
    function automatic quat_t quat_of_matrix(input matrix_t mat);
        logic signed [63:0] r[9];
        logic signed [63:0] one, tr;
        logic signed [63:0] v[4];
        logic [63:0] mag[4];
        logic [63:0] maxm, sumsq, n, q;
        logic [127:0] num;
        logic neg[4];
        quat_t res;
        one = 64'sd1 << FB;
        for (int i = 0; i < 9; i++) r[i] = $signed(mat[32*i +: 32]);
        tr = r[0] + r[4] + r[8];
        if (tr > 0) begin
            v[0] = one + tr; v[1] = r[7] - r[5]; v[2] = r[2] - r[6]; v[3] = r[3] - r[1];
        end else if (r[0] > r[4] && r[0] > r[8]) begin
            v[0] = r[7] - r[5]; v[1] = one + r[0] - r[4] - r[8];
            v[2] = r[1] + r[3]; v[3] = r[2] + r[6];
            if (v[1] < 0) v[1] = 0;
        end else if (r[4] > r[8]) begin
            v[0] = r[2] - r[6]; v[1] = r[1] + r[3];
            v[2] = one + r[4] - r[0] - r[8]; v[3] = r[5] + r[7];
            if (v[2] < 0) v[2] = 0;
        end else begin
            v[0] = r[3] - r[1]; v[1] = r[2] + r[6];
            v[2] = r[5] + r[7]; v[3] = one + r[8] - r[0] - r[4];
            if (v[3] < 0) v[3] = 0;
        end
        maxm = 0;
        for (int i = 0; i < 4; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? -v[i] : v[i];
            if (mag[i] > maxm) maxm = mag[i];
        end
        if (maxm == 0) return '0;
        // bring largest magnitude into [2^29, 2^30)
        while (maxm >= (64'd1 << 30)) begin
            maxm >>= 1;
            for (int i = 0; i < 4; i++) mag[i] >>= 1;
        end
        while (maxm < (64'd1 << 29)) begin
            maxm <<= 1;
            for (int i = 0; i < 4; i++) mag[i] <<= 1;
        end
        sumsq = 0;
        for (int i = 0; i < 4; i++) sumsq += mag[i] * mag[i];
        n = isqrt(sumsq);
        for (int i = 0; i < 4; i++) begin
            num = {64'd0, mag[i]} << (FB + 1);
            q = 64'(((num / n) + 1) >> 1);
            if (neg[i]) begin
                if (q > 64'h8000_0000) q = 64'h8000_0000;
                res[32*i +: 32] = -q[31:0];
            end else begin
                if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
                res[32*i +: 32] = q[31:0];
            end
        end
        return res;
    endfunction

    function automatic matrix_t pack_mat(input logic signed [31:0] a, b, c, d, e, f,
                                         g, h, k);
        return {k, h, g, f, e, d, c, b, a};
    endfunction

    function automatic logic [31:0] near(input logic signed [31:0] x, input int spread);
        return x + $signed($urandom_range(2 * spread)) - spread;
    endfunction

    // Near-rotation matrix: signed permutation with small perturbation
    function automatic matrix_t rand_rotation();
        logic signed [31:0] e[9];
        int p;
        int spread;
        p = $urandom_range(5);
        spread = 1 << $urandom_range(28, 4);
        for (int i = 0; i < 9; i++) e[i] = near(0, spread);
        for (int row = 0; row < 3; row++) begin
            int col;
            col = (p < 3) ? (row + p) % 3 : (3 - row + p) % 3;
            e[3*row + col] = near($urandom_range(1) ? ONE_Q : -ONE_Q, spread);
        end
        return pack_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
    endfunction

    task automatic report_mismatch(input string what, input quat_t got, input quat_t exp);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $time);
        err_count++;
    endtask

    // Driver: bursts and gaps, with a pause for draining on request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) pending_mats.pop_front();
            if (drain_req && !(s_tvalid && !s_tready)) begin
                s_tvalid <= 1'b0;
                if (quat_expected.size() == 0 && !(s_tvalid && s_tready)) drain_req <= 1'b0;
            end else if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pending_mats.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_mats[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= $urandom_range(3) == 0 ? 0 : $urandom_range(6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    always @(posedge aclk) begin
        if (hold_req && hold_left == 0) begin
            hold_left <= 400;
            hold_req <= 1'b0;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= (hold_left == 1);
        end else begin
            m_tready <= ($time / 1000) % 3 == 0 ? 1'b1 : ($urandom_range(3) != 0);
        end
    end

    // Monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                quat_expected.push_back(quat_of_matrix(s_tdata));
            if (m_tvalid && m_tready) begin
                if (quat_expected.size() == 0) begin
                    report_mismatch("unexpected transaction", m_tdata, '0);
                end else begin
                    quat_t exp_q;
                    exp_q = quat_expected.pop_front();
                    for (int i = 0; i < 4; i++)
                        if (m_tdata[32*i +: 32] !== exp_q[32*i +: 32])
                            report_mismatch($sformatf("quat field %0d", i), m_tdata, exp_q);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else if (!stim_done || quat_expected.size() > 0) idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("Watchdog timeout");
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic signed [31:0] e[9];
        // directed: identity, each branch, extremes, degenerate cases
        pending_mats.push_back(pack_mat(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q));
        pending_mats.push_back(pack_mat(ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
        pending_mats.push_back(pack_mat(-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q));
        pending_mats.push_back(pack_mat(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q));
        pending_mats.push_back(pack_mat(0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q));
        pending_mats.push_back('0);
        pending_mats.push_back({9{MAXP}});
        pending_mats.push_back({9{MAXN}});
        pending_mats.push_back(pack_mat(MAXN, MAXP, MAXN, MAXP, MAXN, MAXP, MAXN, MAXP,
                                        MAXN));
        pending_mats.push_back(pack_mat(MAXN, 0, 0, 0, MAXN, 0, 0, 0, MAXN));
        pending_mats.push_back(pack_mat(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q));
        pending_mats.push_back(pack_mat(MAXP, 0, 0, 0, MAXN, 0, 0, 0, MAXN));
        pending_mats.push_back(pack_mat(-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, MAXN));
        pending_mats.push_back(pack_mat(0, MAXP, MAXN, MAXN, 0, MAXP, MAXP, MAXN, 0));
        pending_mats.push_back(pack_mat(-5, 1, 0, 0, -7, 0, 0, 0, -3 * ONE_Q / 2));
        pending_mats.push_back(pack_mat(1, 0, 0, 0, 0, 0, 0, 0, -1));
        for (int k = 0; k < 800; k++) begin
            if ($urandom_range(9) < 7) begin
                pending_mats.push_back(rand_rotation());
            end else begin
                for (int i = 0; i < 9; i++)
                    e[i] = $urandom_range(1) ? $urandom() : near(0, 1 << $urandom_range(31));
                pending_mats.push_back(pack_mat(e[0], e[1], e[2], e[3], e[4], e[5], e[6],
                                                e[7], e[8]));
            end
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        // long receiver hold while items keep coming
        wait (pending_mats.size() < 700);
        @(posedge aclk);
        hold_req <= 1'b1;
        wait (pending_mats.size() < 300);
        @(posedge aclk);
        drain_req <= 1'b1;
        wait (pending_mats.size() == 0);
        stim_done = 1'b1;
        wait (quat_expected.size() == 0);
        repeat (100) @(posedge aclk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
